// ----- hdl/gcc_pkg.sv -----
// Package for the graph connectivity checker.
// Shared widths and default sizes; no dependencies.
package gcc_pkg;

  // Default number of vertex slots (rows and columns of the edge matrix).
  localparam int VERTICES_DEFAULT = 64;

  // Fixed widths of the word fields.
  localparam int VERTEX_W = 6;
  localparam int COUNT_W  = 7;

endpackage

// ----- hdl/gcc_ram.sv -----
// Generic simple dual-port RAM: one write port with bit mask, one registered read port.
// No dependencies.
module gcc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_mask,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int i = 0; i < WIDTH; i++) begin
        if (wr_mask[i]) begin
          mem[wr_addr][i] <= wr_data[i];
        end
      end
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hdl/graph_connectivity_check_core.sv -----
// Top level of the undirected graph connectivity checker.
// Depends on gcc_pkg and gcc_ram (edge matrix storage).

// Undirected graph connectivity checker. Each input word carries one edge
// (from_vertex, to_vertex) when edge_valid is set; both endpoints must be
// below VERTICES or the edge is dropped. The edge sets both mirror bits of
// a VERTICES x VERTICES adjacency matrix held in a RAM, and marks both
// endpoints as seen. A word with last_edge set closes the graph: after its
// own edge, a reachability search runs from vertex 0, and one result word
// follows with connected (every seen vertex reached), vertex_count and
// reached_count (seen vertices that were reached). An empty graph reports
// connected with both counts zero. All stores are then cleared at once
// through per-row valid flops, so there is no clearing pass, after reset
// or between graphs. An edge word passes through WRITE_B after its accept,
// since the single RAM write port sets the two mirror rows one after the
// other. The search is a pointer sweep over the pending set; each pending
// vertex takes a row read (SCAN), then a merge (EXPAND), each skipped slot
// only a pointer step in SCAN, and the sweep ends when nothing is pending.
// A serial count over all VERTICES slots (COUNT) and the load of the result
// (FINISH) follow. The block takes no new word during the search and count;
// a finished result waits in its output register while the block is idle.
module graph_connectivity_check_core #(
  parameter int VERTICES = gcc_pkg::VERTICES_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  // input channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [gcc_pkg::VERTEX_W-1:0] from_vertex,
  input  logic [gcc_pkg::VERTEX_W-1:0] to_vertex,
  input  logic                         edge_valid,
  input  logic                         last_edge,
  // result channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         connected,
  output logic [gcc_pkg::COUNT_W-1:0]  vertex_count,
  output logic [gcc_pkg::COUNT_W-1:0]  reached_count
);

  localparam int VW = $clog2(VERTICES);

  typedef enum logic [2:0] {
    IDLE,     // waiting for a word
    WRITE_B,  // second mirror row of an edge
    SCAN,     // look at pending bit under the pointer
    EXPAND,   // merge the fetched row into reached / pending
    COUNT,    // serial popcount of seen and seen & reached
    FINISH    // load result, clear stores
  } state_t;

  state_t state;

  logic [VERTICES-1:0] seen_vertices;
  logic [VERTICES-1:0] reached_vertices;
  logic [VERTICES-1:0] pending_vertices;
  logic [VERTICES-1:0] row_valid;      // row holds data written in this graph
  logic [VW-1:0]       a_idx;          // held endpoints for the mirror write
  logic [VW-1:0]       b_idx;
  logic                last_hold;
  logic [VW-1:0]       ptr;
  logic                fetch_ok;       // fetched row was written this graph
  logic [gcc_pkg::COUNT_W-1:0] seen_cnt;
  logic [gcc_pkg::COUNT_W-1:0] reach_cnt;

  logic                accept;
  logic                edge_ok;
  logic [VW-1:0]       in_a;
  logic [VW-1:0]       in_b;
  logic                ptr_last;
  logic [VW-1:0]       ptr_next;

  // RAM ports
  logic                wr_en;
  logic [VW-1:0]       wr_addr;
  logic [VERTICES-1:0] wr_bit;
  logic [VERTICES-1:0] wr_mask;
  logic                rd_en;
  logic [VERTICES-1:0] rd_data;
  logic [VERTICES-1:0] row;
  logic [VERTICES-1:0] fresh;

  assign in_ready = (state == IDLE);
  assign accept   = in_valid && in_ready;
  assign in_a     = VW'(from_vertex);
  assign in_b     = VW'(to_vertex);
  // endpoints beyond the matrix drop the whole edge
  assign edge_ok  = edge_valid && (int'(from_vertex) < VERTICES)
                    && (int'(to_vertex) < VERTICES);

  assign ptr_last = (ptr == VW'(VERTICES - 1));
  assign ptr_next = ptr_last ? '0 : ptr + VW'(1);

  // Row a is written in the accept cycle, row b in WRITE_B. A row not yet
  // valid gets a full-width write so stale bits from an old graph vanish.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = in_a;
    wr_bit  = VERTICES'(1) << in_b;
    if (state == WRITE_B) begin
      wr_en   = 1'b1;
      wr_addr = b_idx;
      wr_bit  = VERTICES'(1) << a_idx;
    end else if (accept && edge_ok) begin
      wr_en   = 1'b1;
    end
    wr_mask = row_valid[wr_addr] ? wr_bit : '1;
  end

  assign rd_en = (state == SCAN) && pending_vertices[ptr];
  assign row   = fetch_ok ? rd_data : '0;
  assign fresh = row & ~reached_vertices;

  gcc_ram #(
    .WIDTH (VERTICES),
    .DEPTH (VERTICES)
  ) u_adj (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_mask (wr_mask),
    .wr_data (wr_bit),
    .rd_en   (rd_en),
    .rd_addr (ptr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= IDLE;
      seen_vertices    <= '0;
      reached_vertices <= '0;
      pending_vertices <= '0;
      row_valid        <= '0;
      ptr              <= '0;
      out_valid        <= 1'b0;
    end else begin
      // FINISH reloads the output register itself
      if (out_valid && out_ready && (state != FINISH)) begin
        out_valid <= 1'b0;
      end
      if (wr_en) begin
        row_valid[wr_addr] <= 1'b1;
      end

      unique case (state)
        IDLE: begin
          if (accept) begin
            a_idx     <= in_a;
            b_idx     <= in_b;
            last_hold <= last_edge;
            if (edge_ok) begin
              seen_vertices <= seen_vertices | (VERTICES'(1) << in_a)
                               | (VERTICES'(1) << in_b);
              state <= WRITE_B;
            end else if (last_edge) begin
              // search seeds at vertex 0, seen or not
              reached_vertices <= VERTICES'(1);
              pending_vertices <= VERTICES'(1);
              ptr              <= '0;
              state            <= SCAN;
            end
          end
        end

        WRITE_B: begin
          if (last_hold) begin
            reached_vertices <= VERTICES'(1);
            pending_vertices <= VERTICES'(1);
            ptr              <= '0;
            state            <= SCAN;
          end else begin
            state <= IDLE;
          end
        end

        SCAN: begin
          if (pending_vertices == '0) begin
            ptr       <= '0;
            seen_cnt  <= '0;
            reach_cnt <= '0;
            state     <= COUNT;
          end else if (pending_vertices[ptr]) begin
            pending_vertices[ptr] <= 1'b0;
            fetch_ok              <= row_valid[ptr];
            state                 <= EXPAND;
          end else begin
            ptr <= ptr_next;
          end
        end

        EXPAND: begin
          reached_vertices <= reached_vertices | fresh;
          pending_vertices <= pending_vertices | fresh;
          ptr              <= ptr_next;
          state            <= SCAN;
        end

        COUNT: begin
          seen_cnt  <= seen_cnt + gcc_pkg::COUNT_W'(seen_vertices[ptr]);
          reach_cnt <= reach_cnt
                       + gcc_pkg::COUNT_W'(seen_vertices[ptr] & reached_vertices[ptr]);
          ptr       <= ptr_next;
          if (ptr_last) begin
            state <= FINISH;
          end
        end

        FINISH: begin
          // wait until the previous result has been taken
          if (!out_valid || out_ready) begin
            out_valid        <= 1'b1;
            connected        <= (seen_cnt == reach_cnt);
            vertex_count     <= seen_cnt;
            reached_count    <= reach_cnt;
            seen_vertices    <= '0;
            reached_vertices <= '0;
            pending_vertices <= '0;
            row_valid        <= '0;
            state            <= IDLE;
          end
        end

        default: state <= IDLE;
      endcase
    end
  end

  // pending vertices are always a subset of reached ones
  a_pending_in_reached: assert property (@(posedge clk) disable iff (rst)
    (pending_vertices & ~reached_vertices) == '0)
    else $error("pending vertex not marked reached");

  // between graphs the search sets are empty
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (state == IDLE) |-> (reached_vertices == '0 && pending_vertices == '0))
    else $error("search sets not cleared after result");

  // no matrix writes while the search or count runs
  a_no_write_in_search: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == IDLE || state == WRITE_B))
    else $error("matrix written outside edge loading");

  // a fresh result is consistent with its counts
  a_result_consistent: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> (connected == (vertex_count == reached_count)
                          && reached_count <= vertex_count))
    else $error("result flag disagrees with counts");

  // a fetched row always comes back in the merge cycle
  a_fetch_then_expand: assert property (@(posedge clk) disable iff (rst)
    rd_en |=> (state == EXPAND))
    else $error("row fetch not followed by merge");

endmodule
